// ===== rtl/core/bfie_pkg.sv =====
// Shared constants, command codes and controller/datapath link types
// for the bit field insert/extract block. No dependencies.
package bfie_pkg;

  // Buffer geometry and field limits
  localparam int BUFFER_BYTES   = 256;
  localparam int MAX_FIELD_BITS = 64;
  localparam int ADDR_W         = $clog2(BUFFER_BYTES);
  localparam int BUFFER_BITS    = BUFFER_BYTES * 8;

  // Span window: up to nine bytes for a 64-bit field at any bit phase
  localparam int WIN_BYTES = 9;
  localparam int WIN_W     = WIN_BYTES * 8;

  // Command codes
  localparam logic [1:0] CMD_WRITE_BYTE = 2'd0;
  localparam logic [1:0] CMD_READ_BYTE  = 2'd1;
  localparam logic [1:0] CMD_INSERT     = 2'd2;
  localparam logic [1:0] CMD_EXTRACT    = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the input word
    logic prep;    // build merge data and mask, clear counters
    logic issue;   // read the next buffer byte of the span
    logic align;   // shift the gathered window to the top of the word
    logic finish;  // register the result and raise the strobe
  } bfie_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic skip;    // nothing to touch: out of range or empty field
    logic last;    // this issue reads the final byte of the span
  } bfie_stat_t;

  // Mask with the top len bits of a 64-bit word set
  function automatic logic [63:0] top_mask(input logic [6:0] len);
    top_mask = ~({64{1'b1}} >> len);
  endfunction

endpackage

// ===== rtl/core/bit_field_insert_extract.sv =====
// Bit field insert/extract over a zero-reset byte buffer, MSB-first bits.
// Each command is taken when start is high and busy low. The result word
// appears on read_value, byte_count and out_of_range for exactly one cycle
// with done high; the receiver cannot stall it. A field command that spans
// N buffer bytes (N = ceil((bit_offset%8 + field_length)/8), up to 9) reads
// them, and for an insert rewrites them, through the buffer RAM's single read
// and single write port one byte a cycle; a raw byte access touches one byte
// and an out-of-range or empty field none. A new command is taken only once
// the current one has finished. Depends on bfie_pkg, bfie_ctrl, bfie_dp and bfie_ram.
module bit_field_insert_extract
  import bfie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  byte_address,
  input  logic [7:0]  write_byte,
  input  logic [10:0] bit_offset,
  input  logic [6:0]  field_length,
  input  logic [63:0] field_value,
  input  logic        right_aligned,
  output logic        done,
  output logic [63:0] read_value,
  output logic [3:0]  byte_count,
  output logic        out_of_range
);

  bfie_cmd_t  cmd;
  bfie_stat_t stat;

  // Sequence the commands
  bfie_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the buffer and compute the result
  bfie_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .command       (command),
    .byte_address  (byte_address),
    .write_byte    (write_byte),
    .bit_offset    (bit_offset),
    .field_length  (field_length),
    .field_value   (field_value),
    .right_aligned (right_aligned),
    .read_value    (read_value),
    .byte_count    (byte_count),
    .out_of_range  (out_of_range),
    .done          (done)
  );

endmodule

// ===== rtl/core/bfie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bfie_ctrl.sv =====
// Controller state machine for the bit field insert/extract block.
// Depends on bfie_pkg for the command and status types.
module bfie_ctrl
  import bfie_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  bfie_stat_t stat,
  output bfie_cmd_t  cmd,
  output logic       busy
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_ALIGN = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the command sequence
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = stat.skip ? ST_ALIGN : ST_READ;
      end
      ST_READ: begin
        cmd.issue = 1'b1;
        if (stat.last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd.align  = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/core/bfie_dp.sv =====
// Datapath for the bit field insert/extract block: word capture, span
// read-merge-write over the byte buffer, window alignment and result.
// Depends on bfie_pkg and bfie_ram.
module bfie_dp
  import bfie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  bfie_cmd_t   cmd,
  output bfie_stat_t  stat,
  input  logic [1:0]  command,
  input  logic [7:0]  byte_address,
  input  logic [7:0]  write_byte,
  input  logic [10:0] bit_offset,
  input  logic [6:0]  field_length,
  input  logic [63:0] field_value,
  input  logic        right_aligned,
  output logic [63:0] read_value,
  output logic [3:0]  byte_count,
  output logic        out_of_range,
  output logic        done
);

  // Captured input word
  logic [1:0]  cmd_q;
  logic [7:0]  addr_q;
  logic [7:0]  wbyte_q;
  logic [10:0] off_q;
  logic [6:0]  len_q;
  logic [63:0] val_q;
  logic        right_q;

  // Span state
  logic [WIN_W-1:0]  fw;      // field data placed in the span window
  logic [WIN_W-1:0]  mw;      // bits of the window that are written
  logic [WIN_W-1:0]  win;     // bytes gathered from the buffer
  logic [3:0]        rd_cnt;  // bytes issued
  logic [3:0]        kt;      // bytes taken back
  logic              dv;      // read data arrives this cycle
  logic [ADDR_W-1:0] ta;      // address of the byte arriving
  logic              vld_q;   // that byte has been written since reset
  logic [63:0]       left;    // field, top-aligned

  logic [BUFFER_BYTES-1:0] valid;

  // Decoded command and span figures
  logic              is_byte;
  logic              is_wr;
  logic              oor;
  logic [3:0]        nb;
  logic [ADDR_W-1:0] start_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [6:0]        pos;
  logic [7:0]        old_byte;
  logic [7:0]        fwb;
  logic [7:0]        mwb;
  logic [7:0]        ram_rdata;
  logic [7:0]        ram_wdata;
  logic              ram_we;
  logic [63:0]       lv;
  logic [63:0]       tmask;
  logic [WIN_W-1:0]  win_sh;
  logic [19:0]       field_end;

  assign is_byte = (cmd_q == CMD_WRITE_BYTE) || (cmd_q == CMD_READ_BYTE);
  assign is_wr   = (cmd_q == CMD_WRITE_BYTE) || (cmd_q == CMD_INSERT);

  // Range check
  assign field_end = 20'(off_q) + 20'(len_q);
  always_comb begin
    if (is_byte) begin
      oor = ({24'd0, addr_q} >= 32'(BUFFER_BYTES));
    end else begin
      oor = (len_q > 7'(MAX_FIELD_BITS)) || (field_end > 20'(BUFFER_BITS));
    end
  end

  // Bytes spanned and first byte
  always_comb begin
    if (oor) begin
      nb = 4'd0;
    end else if (is_byte) begin
      nb = 4'd1;
    end else if (len_q == 7'd0) begin
      nb = 4'd0;
    end else begin
      nb = 4'((8'(off_q[2:0]) + 8'(len_q) + 8'd7) >> 3);
    end
  end

  assign start_addr = is_byte ? ADDR_W'(addr_q) : ADDR_W'(off_q[10:3]);
  assign rd_addr    = ADDR_W'(start_addr + ADDR_W'(rd_cnt));

  assign stat.skip = (nb == 4'd0);
  assign stat.last = (4'(rd_cnt + 4'd1) == nb);

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= command;
      addr_q  <= byte_address;
      wbyte_q <= write_byte;
      off_q   <= bit_offset;
      len_q   <= field_length;
      val_q   <= field_value;
      right_q <= right_aligned;
    end
  end

  // Top-align the value and mask it to the field
  assign tmask = top_mask(len_q);
  assign lv    = (right_q ? (val_q << (7'd64 - len_q)) : val_q) & tmask;

  // Build merge data and mask over the span window
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      if (cmd_q == CMD_WRITE_BYTE) begin
        fw <= {wbyte_q, 64'd0};
        mw <= {8'hFF, 64'd0};
      end else begin
        fw <= {lv, 8'd0} >> off_q[2:0];
        mw <= {tmask, 8'd0} >> off_q[2:0];
      end
    end
  end

  // Issue counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else begin
      dv <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rd_cnt <= 4'd0;
    end else if (cmd.issue) begin
      rd_cnt <= 4'(rd_cnt + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ta    <= rd_addr;
      vld_q <= valid[rd_addr];
    end
  end

  // Merge the arriving byte with the field; the first byte sits at the top
  assign pos       = {4'(4'd8 - kt), 3'b000};
  assign old_byte  = vld_q ? ram_rdata : 8'd0;
  assign fwb       = fw[pos +: 8];
  assign mwb       = mw[pos +: 8];
  assign ram_wdata = (old_byte & ~mwb) | (fwb & mwb);
  assign ram_we    = dv && is_wr;

  // Gather bytes into the window
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      kt  <= 4'd0;
      win <= '0;
    end else if (dv) begin
      kt          <= 4'(kt + 4'd1);
      win[pos +: 8] <= old_byte;
    end
  end

  // Mark written entries; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[ta] <= 1'b1;
    end
  end

  bfie_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ta),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Shift the window so the field starts at the top bit
  assign win_sh = win << off_q[2:0];

  always_ff @(posedge clk) begin
    if (cmd.align) begin
      left <= win_sh[WIN_W-1:8] & tmask;
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_of_range <= oor;
      if (oor) begin
        byte_count <= 4'd0;
        read_value <= 64'd0;
      end else begin
        byte_count <= is_byte ? 4'd1 : 4'((8'(len_q) + 8'd7) >> 3);
        case (cmd_q)
          CMD_READ_BYTE: read_value <= {56'd0, win[WIN_W-1 -: 8]};
          CMD_EXTRACT:   read_value <= right_q ? (left >> (7'd64 - len_q)) : left;
          default:       read_value <= 64'd0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

// ===== rtl/core/bfie_checker.sv =====
// Port-level checks for bit_field_insert_extract, bound to the top level.
// Depends on bfie_pkg.
module bfie_checker
  import bfie_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [63:0] read_value,
  input logic [3:0]  byte_count,
  input logic        out_of_range
);

  // An accepted word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // The strobe comes only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // The strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // A refused request reports nothing
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (byte_count == 4'd0) && (read_value == 64'd0))
    else $error("out of range result carries data");

  // Never more than eight bytes of field data
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (byte_count <= 4'd8))
    else $error("byte count too large");

endmodule

bind bit_field_insert_extract bfie_checker u_bfie_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .read_value   (read_value),
  .byte_count   (byte_count),
  .out_of_range (out_of_range)
);

// ===== tb/bit_field_insert_extract_checker.sv =====
// Checker for bit_field_insert_extract: keeps its own image of the byte buffer,
// predicts each accepted word's result and compares it with the strobed result.
// Depends on bfie_pkg for the command codes and buffer geometry.
module bit_field_insert_extract_checker
  import bfie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  command,
  input  logic [7:0]  byte_address,
  input  logic [7:0]  write_byte,
  input  logic [10:0] bit_offset,
  input  logic [6:0]  field_length,
  input  logic [63:0] field_value,
  input  logic        right_aligned,
  input  logic        done,
  input  logic [63:0] read_value,
  input  logic [3:0]  byte_count,
  input  logic        out_of_range,
  output int          mismatches,
  output int          awaiting
);

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  count;
    logic        oor;
  } field_result_t;

  logic [7:0]    buffer_image [BUFFER_BYTES];
  field_result_t pending_results [$];

  // Apply one command to the buffer image and work out its result
  task automatic predict_word(input logic [1:0] cmd, input logic [7:0] addr,
                              input logic [7:0] wbyte, input logic [10:0] off,
                              input logic [6:0] len, input logic [63:0] fval,
                              input logic right, output field_result_t res);
    int bit_pos;
    int word_pos;
    res = '0;
    if (cmd == CMD_WRITE_BYTE || cmd == CMD_READ_BYTE) begin
      if (int'(addr) >= BUFFER_BYTES) begin
        res.oor = 1'b1;
      end else begin
        res.count = 4'd1;
        if (cmd == CMD_WRITE_BYTE) buffer_image[addr] = wbyte;
        else res.value = {56'd0, buffer_image[addr]};
      end
    end else if (int'(len) > MAX_FIELD_BITS || int'(off) + int'(len) > BUFFER_BITS) begin
      res.oor = 1'b1;
    end else begin
      res.count = 4'((int'(len) + 7) / 8);
      // walk the field MSB-first; word position depends on alignment
      for (int i = 0; i < int'(len); i++) begin
        bit_pos  = int'(off) + i;
        word_pos = right ? int'(len) - 1 - i : 63 - i;
        if (cmd == CMD_INSERT)
          buffer_image[bit_pos / 8][7 - (bit_pos % 8)] = fval[word_pos];
        else
          res.value[word_pos] = buffer_image[bit_pos / 8][7 - (bit_pos % 8)];
      end
    end
  endtask

  always @(posedge clk) begin
    field_result_t predicted;
    field_result_t oldest;
    if (rst) begin
      foreach (buffer_image[i]) buffer_image[i] = 8'd0;
      pending_results.delete();
      mismatches = 0;
      awaiting   = 0;
    end else begin
      // compare a strobed result with the oldest prediction first
      if (done) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result with nothing outstanding: value=%h count=%0d oor=%b",
                     $time, read_value, byte_count, out_of_range);
        end else begin
          oldest = pending_results.pop_front();
          if (oldest.value !== read_value || oldest.count !== byte_count ||
              oldest.oor !== out_of_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: value exp %h got %h, count exp %0d got %0d, oor exp %b got %b",
                       $time, oldest.value, read_value, oldest.count, byte_count,
                       oldest.oor, out_of_range);
          end
        end
      end
      // predict the word accepted at this edge
      if (start && !busy) begin
        predict_word(command, byte_address, write_byte, bit_offset, field_length,
                     field_value, right_aligned, predicted);
        pending_results.push_back(predicted);
      end
      awaiting = pending_results.size();
    end
  end

endmodule

// ===== tb/bit_field_insert_extract_tb.sv =====
// Testbench top for bit_field_insert_extract: drives directed and random
// command words, watches for a stall and gives the verdict. Depends on bfie_pkg,
// the block itself and bit_field_insert_extract_checker.
module bit_field_insert_extract_tb;
  import bfie_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = CMD_WRITE_BYTE;
  logic [7:0]  byte_address = '0;
  logic [7:0]  write_byte = '0;
  logic [10:0] bit_offset = '0;
  logic [6:0]  field_length = '0;
  logic [63:0] field_value = '0;
  logic        right_aligned = 1'b0;
  logic        done;
  logic [63:0] read_value;
  logic [3:0]  byte_count;
  logic        out_of_range;
  int          mismatches;
  int          awaiting;
  int          idle_pct = 0;
  int          stall_cycles = 0;

  always #4 clk = ~clk;

  bit_field_insert_extract DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .byte_address(byte_address), .write_byte(write_byte), .bit_offset(bit_offset),
    .field_length(field_length), .field_value(field_value),
    .right_aligned(right_aligned), .done(done), .read_value(read_value),
    .byte_count(byte_count), .out_of_range(out_of_range)
  );

  bit_field_insert_extract_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .byte_address(byte_address), .write_byte(write_byte), .bit_offset(bit_offset),
    .field_length(field_length), .field_value(field_value),
    .right_aligned(right_aligned), .done(done), .read_value(read_value),
    .byte_count(byte_count), .out_of_range(out_of_range),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  // Count cycles with no accepted word and no result; abort on a hang
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one word from a falling edge; return at the falling edge after its accept
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] addr,
                           input logic [7:0] wbyte, input logic [10:0] off,
                           input logic [6:0] len, input logic [63:0] fval,
                           input logic right);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    command       <= cmd;
    byte_address  <= addr;
    write_byte    <= wbyte;
    bit_offset    <= off;
    field_length  <= len;
    field_value   <= fval;
    right_aligned <= right;
    start         <= 1'b1;
    // busy only moves on a rising edge, so its value here decides the next accept
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Random word: fields mostly in range, often in a small hot region of the buffer
  task automatic send_random_word();
    logic [6:0]  len;
    logic [10:0] off;
    logic [7:0]  addr;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       len = 7'd0;
    else if (pick < 20) len = 7'd64;
    else if (pick < 30) len = 7'($urandom_range(65, 127));
    else                len = 7'($urandom_range(1, 63));
    pick = $urandom_range(0, 99);
    if (pick < 45)      off = 11'($urandom_range(0, 127));
    else if (pick < 85) off = 11'($urandom_range(0, BUFFER_BITS - (len > 64 ? 64 : len)));
    else                off = 11'($urandom_range(0, BUFFER_BITS - 1));
    addr = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    send_word(2'($urandom_range(0, 3)), addr, 8'($urandom_range(0, 255)), off, len,
              {$urandom, $urandom}, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    // hold reset, release it on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: raw bytes at both ends of the buffer
    send_word(CMD_WRITE_BYTE, 8'd0, 8'hFF, 11'd0, 7'd0, 64'd0, 1'b0);
    send_word(CMD_WRITE_BYTE, 8'd255, 8'h80, 11'd0, 7'd0, 64'd0, 1'b0);
    send_word(CMD_READ_BYTE, 8'd0, 8'd0, 11'd0, 7'd0, 64'd0, 1'b0);
    send_word(CMD_READ_BYTE, 8'd255, 8'd0, 11'd0, 7'd0, 64'd0, 1'b0);
    send_word(CMD_READ_BYTE, 8'd7, 8'd0, 11'd0, 7'd0, 64'd0, 1'b0);
    // full-width fields at offset zero and across nine bytes
    send_word(CMD_INSERT, 8'd0, 8'd0, 11'd0, 7'd64, 64'hF0E1_D2C3_B4A5_9687, 1'b0);
    send_word(CMD_EXTRACT, 8'd0, 8'd0, 11'd0, 7'd64, 64'd0, 1'b1);
    send_word(CMD_INSERT, 8'd0, 8'd0, 11'd5, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_word(CMD_EXTRACT, 8'd0, 8'd0, 11'd3, 7'd64, 64'd0, 1'b0);
    send_word(CMD_READ_BYTE, 8'd8, 8'd0, 11'd0, 7'd0, 64'd0, 1'b0);
    // short fields at odd bit phases, both alignments, neighbours kept
    send_word(CMD_INSERT, 8'd0, 8'd0, 11'd19, 7'd13, 64'h0000_0000_0000_0AAA, 1'b1);
    send_word(CMD_INSERT, 8'd0, 8'd0, 11'd35, 7'd7, 64'h5400_0000_0000_0000, 1'b0);
    send_word(CMD_EXTRACT, 8'd0, 8'd0, 11'd16, 7'd32, 64'd0, 1'b1);
    // fields touching and crossing the buffer end
    send_word(CMD_INSERT, 8'd0, 8'd0, 11'd1984, 7'd64, 64'h0123_4567_89AB_CDEF, 1'b1);
    send_word(CMD_EXTRACT, 8'd0, 8'd0, 11'd1984, 7'd64, 64'd0, 1'b0);
    send_word(CMD_INSERT, 8'd0, 8'd0, 11'd1985, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(CMD_INSERT, 8'd0, 8'd0, 11'd2047, 7'd1, 64'd1, 1'b1);
    send_word(CMD_EXTRACT, 8'd0, 8'd0, 11'd2047, 7'd1, 64'd0, 1'b0);
    send_word(CMD_EXTRACT, 8'd0, 8'd0, 11'd2047, 7'd2, 64'd0, 1'b0);
    // over-long and empty fields
    send_word(CMD_EXTRACT, 8'd0, 8'd0, 11'd0, 7'd65, 64'd0, 1'b0);
    send_word(CMD_INSERT, 8'd0, 8'd0, 11'd0, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_word(CMD_INSERT, 8'd0, 8'd0, 11'd8, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(CMD_EXTRACT, 8'd0, 8'd0, 11'd8, 7'd0, 64'd0, 1'b1);
    send_word(CMD_READ_BYTE, 8'd1, 8'd0, 11'd0, 7'd0, 64'd0, 1'b0);

    // random: sender idles seldom, then often, then never
    idle_pct = 23;
    repeat (500) send_random_word();
    idle_pct = 47;
    repeat (500) send_random_word();
    idle_pct = 0;
    repeat (500) send_random_word();

    // drop start and drain outstanding results
    start <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bfie_pkg.sv
rtl/core/bfie_ram.sv
rtl/core/bfie_ctrl.sv
rtl/core/bfie_dp.sv
rtl/core/bit_field_insert_extract.sv
rtl/core/bfie_checker.sv
tb/bit_field_insert_extract_checker.sv
tb/bit_field_insert_extract_tb.sv
